/* src/grb_pkg.sv */
// Shared types, constants and helpers for the GPIO register block.
`timescale 1ns / 1ps

package grb_pkg;

   localparam int NUM_PINS      = 54;
   localparam int FSEL_MAX_PINS = 60;
   localparam int FSEL_PINS     = (NUM_PINS < FSEL_MAX_PINS) ? NUM_PINS : FSEL_MAX_PINS;
   localparam int FSEL_BITS     = 3;
   localparam int FSEL_PER_WORD = 10;
   localparam int NUM_DETECT    = 6;
   localparam int WORD_W        = 32;
   localparam int ADDR_W        = 6;

   localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'b001;

   // word map
   localparam logic [ADDR_W-1:0] ADDR_FSEL_LAST = 6'd5;
   localparam logic [ADDR_W-1:0] ADDR_SET       = 6'd7;
   localparam logic [ADDR_W-1:0] ADDR_CLR       = 6'd10;
   localparam logic [ADDR_W-1:0] ADDR_LEV       = 6'd13;
   localparam logic [ADDR_W-1:0] ADDR_STS       = 6'd16;
   localparam int                ADDR_DET_BASE  = 19;
   localparam int                ADDR_DET_STEP  = 3;

   // detect bank order
   localparam int DET_RISE   = 0;
   localparam int DET_FALL   = 1;
   localparam int DET_HIGH   = 2;
   localparam int DET_LOW    = 3;
   localparam int DET_ARISE  = 4;
   localparam int DET_AFALL  = 5;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } grb_req_type;

   typedef logic [NUM_PINS-1:0] grb_pins_type;

   typedef struct packed {
      logic               fire;
      logic [1:0]         req;
      logic [ADDR_W-1:0]  word_addr;
      logic [WORD_W-1:0]  write_data;
      grb_pins_type       pin_levels;
   } grb_access_type;

   typedef struct packed {
      logic [WORD_W-1:0]  read_data;
      grb_pins_type       drive_levels;
      grb_pins_type       drive_enables;
      logic               event_pending;
      logic               bad_address;
   } grb_result_type;

   // 32-bit word placed into the low or high half of a pin vector
   function automatic grb_pins_type place(logic [WORD_W-1:0] d, logic hi);
      logic [63:0] x;
      x = hi ? {d, 32'b0} : {32'b0, d};
      return x[NUM_PINS-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] word_of(grb_pins_type v, logic hi);
      logic [63:0] x;
      x = 64'(v);
      return hi ? x[63:32] : x[31:0];
   endfunction

   function automatic grb_pins_type replace_half(grb_pins_type v, logic [WORD_W-1:0] d,
                                                 logic hi);
      logic [63:0] x;
      x = 64'(v);
      if (hi) begin
         x[63:32] = d;
      end else begin
         x[31:0] = d;
      end
      return x[NUM_PINS-1:0];
   endfunction

endpackage

/* src/grb_regfile.sv */
// Register file: word decode, state update and event detection for one item.
`timescale 1ns / 1ps

module grb_regfile (
   input  logic                    clock,
   input  logic                    reset,
   input  grb_pkg::grb_access_type acc,
   output grb_pkg::grb_result_type res
);
   import grb_pkg::*;

   logic [FSEL_BITS-1:0] fsel_ff [FSEL_PINS];
   logic [FSEL_BITS-1:0] fsel_in [FSEL_PINS];
   grb_pins_type         det_ff  [NUM_DETECT];
   grb_pins_type         det_in  [NUM_DETECT];
   grb_pins_type         latch_ff, latch_in;
   grb_pins_type         sts_ff, sts_in;
   grb_pins_type         prev_ff, prev_in;

   grb_pins_type         cur, sts_clr, ev, dren;
   logic                 wr, mapped;
   logic [WORD_W-1:0]    rd;
   logic [ADDR_W-1:0]    w;

   always_comb begin
      w        = acc.word_addr;
      cur      = acc.pin_levels;
      wr       = (acc.req == REQ_WRITE);
      mapped   = 1'b0;
      rd       = '0;
      fsel_in  = fsel_ff;
      det_in   = det_ff;
      latch_in = latch_ff;
      sts_clr  = sts_ff;

      if (w <= ADDR_FSEL_LAST) begin
         mapped = 1'b1;
         // each pin's select sits at a fixed word and slot
         for (int p = 0; p < FSEL_PINS; p++) begin
            if (w == ADDR_W'(p / FSEL_PER_WORD)) begin
               rd = rd | (WORD_W'(fsel_ff[p]) << (FSEL_BITS * (p % FSEL_PER_WORD)));
               if (wr) begin
                  fsel_in[p] = acc.write_data[FSEL_BITS * (p % FSEL_PER_WORD) +: FSEL_BITS];
               end
            end
         end
      end else if (w == ADDR_SET || w == ADDR_SET + 6'd1) begin
         mapped = 1'b1;
         if (wr) latch_in = latch_ff | place(acc.write_data, w != ADDR_SET);
      end else if (w == ADDR_CLR || w == ADDR_CLR + 6'd1) begin
         mapped = 1'b1;
         if (wr) latch_in = latch_ff & ~place(acc.write_data, w != ADDR_CLR);
      end else if (w == ADDR_LEV || w == ADDR_LEV + 6'd1) begin
         mapped = 1'b1;
         rd     = word_of(cur, w != ADDR_LEV);
      end else if (w == ADDR_STS || w == ADDR_STS + 6'd1) begin
         mapped = 1'b1;
         rd     = word_of(sts_ff, w != ADDR_STS);
         if (wr) sts_clr = sts_ff & ~place(acc.write_data, w != ADDR_STS);
      end else begin
         for (int k = 0; k < NUM_DETECT; k++) begin
            if (w == ADDR_W'(ADDR_DET_BASE + ADDR_DET_STEP * k) ||
                w == ADDR_W'(ADDR_DET_BASE + ADDR_DET_STEP * k + 1)) begin
               mapped = 1'b1;
               rd     = word_of(det_ff[k], w != ADDR_W'(ADDR_DET_BASE + ADDR_DET_STEP * k));
               if (wr) begin
                  det_in[k] = replace_half(det_ff[k], acc.write_data,
                                 w != ADDR_W'(ADDR_DET_BASE + ADDR_DET_STEP * k));
               end
            end
         end
      end

      // detection uses enables after this item's write
      ev = (det_in[DET_RISE]  &  cur & ~prev_ff)
         | (det_in[DET_FALL]  & ~cur &  prev_ff)
         | (det_in[DET_HIGH]  &  cur)
         | (det_in[DET_LOW]   & ~cur)
         | (det_in[DET_ARISE] &  cur & ~prev_ff)
         | (det_in[DET_AFALL] & ~cur &  prev_ff);
      sts_in  = sts_clr | ev;
      prev_in = cur;

      dren = '0;
      for (int p = 0; p < FSEL_PINS; p++) begin
         dren[p] = (fsel_in[p] == FSEL_OUTPUT);
      end

      res.read_data     = (acc.req == REQ_READ && mapped) ? rd : '0;
      res.drive_levels  = latch_in;
      res.drive_enables = dren;
      res.event_pending = |sts_in;
      res.bad_address   = (acc.req == REQ_READ || acc.req == REQ_WRITE) && !mapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < FSEL_PINS; p++) fsel_ff[p] <= '0;
         for (int k = 0; k < NUM_DETECT; k++) det_ff[k] <= '0;
         latch_ff <= '0;
         sts_ff   <= '0;
         prev_ff  <= '0;
      end else if (acc.fire) begin
         fsel_ff  <= fsel_in;
         det_ff   <= det_in;
         latch_ff <= latch_in;
         sts_ff   <= sts_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

/* src/gpio_register_block.sv */
// Top level of the GPIO register block: input register, register file, result register.
// Flow: an accepted item is held in the input register, then passes through the register file
// into the result register when that register is free; its result is taken from there.
// Throughput: one item per cycle when not stalled; the register file updates all state at once.
// Backpressure: rsp_stall holds the result register, and the input stage then fills and stalls.
// Reset (synchronous, active high) clears both stages and all state: function selects to
// input, output latch, event status, detect enables and previous pin sample to zero.
`timescale 1ns / 1ps

module gpio_register_block (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [grb_pkg::ADDR_W-1:0]    req_word_addr,
   input  logic [grb_pkg::WORD_W-1:0]    req_write_data,
   input  logic [grb_pkg::NUM_PINS-1:0]  req_pin_levels,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [grb_pkg::WORD_W-1:0]    rsp_read_data,
   output logic [grb_pkg::NUM_PINS-1:0]  rsp_drive_levels,
   output logic [grb_pkg::NUM_PINS-1:0]  rsp_drive_enables,
   output logic                          rsp_event_pending,
   output logic                          rsp_bad_address
);
   import grb_pkg::*;

   // input stage
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_req_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [WORD_W-1:0]  s1_data_ff;
   grb_pins_type       s1_pins_ff;

   // result stage
   logic               rsp_valid_ff, rsp_valid_in;
   grb_result_type     rsp_ff;

   logic               out_free, advance, accept;
   grb_access_type     acc;
   grb_result_type     res;

   // the result register frees when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // state commits exactly when an item moves into the result register
   assign acc.fire       = advance;
   assign acc.req        = s1_req_ff;
   assign acc.word_addr  = s1_addr_ff;
   assign acc.write_data = s1_data_ff;
   assign acc.pin_levels = s1_pins_ff;

   grb_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff  <= req_type;
         s1_addr_ff <= req_word_addr;
         s1_data_ff <= req_write_data;
         s1_pins_ff <= req_pin_levels;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_drive_levels  = rsp_ff.drive_levels;
   assign rsp_drive_enables = rsp_ff.drive_enables;
   assign rsp_event_pending = rsp_ff.event_pending;
   assign rsp_bad_address   = rsp_ff.bad_address;

   // an item moved forward always shows up as a result
   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("item advanced but no result registered");

   // a held input item is not lost while the output is blocked
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("input stage item dropped");

   // no state commit while a result is stuck
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("stalled result overwritten");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the GPIO register block: directed and random bus traffic.
`timescale 1ns / 1ps

module tb_top;
   import grb_pkg::*;

   // req_type 3 has no name in the package; the block treats it as a tick
   localparam logic [1:0] REQ_SPARE = 2'd3;

   // unmapped words used by the directed tests
   localparam logic [ADDR_W-1:0] ADDR_HOLE_FIRST = 6'd6;
   localparam logic [ADDR_W-1:0] ADDR_DET_END    = 6'd36;
   localparam logic [ADDR_W-1:0] ADDR_HOLE_TOP   = 6'd63;

   localparam logic [63:0] PIN_MASK = (NUM_PINS >= 64) ? '1 : ((64'd1 << NUM_PINS) - 64'd1);
   localparam grb_pins_type ALL_HIGH = '1;
   localparam grb_pins_type ALL_LOW  = '0;

   localparam int IDLE_PCT       = 6;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int QUIET_LIMIT    = 2000;  // cycles with no item moving on either side
   localparam int DRAIN_CYCLES   = 8;

   // every input starts at a known value; reset is high from time zero
   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [1:0]          req_type       = '0;
   logic [ADDR_W-1:0]   req_word_addr  = '0;
   logic [WORD_W-1:0]   req_write_data = '0;
   grb_pins_type        req_pin_levels = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [WORD_W-1:0]   rsp_read_data;
   grb_pins_type        rsp_drive_levels;
   grb_pins_type        rsp_drive_enables;
   logic                rsp_event_pending;
   logic                rsp_bad_address;

   int req_idle_pct  = IDLE_PCT;
   int rsp_stall_pct = IDLE_PCT;
   int error_count   = 0;
   int quiet_cycles  = 0;

   // shadow copy of the block's registers, updated once per accepted item
   logic [FSEL_BITS-1:0] fsel_q [FSEL_PINS] = '{default: '0};
   logic [63:0]          det_q  [NUM_DETECT] = '{default: '0};
   logic [63:0]          latch_q  = '0;
   logic [63:0]          status_q = '0;
   logic [63:0]          prev_q   = '0;

   // results owed by the block, oldest first
   grb_result_type access_results [$];

   gpio_register_block dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_word_addr     (req_word_addr),
      .req_write_data    (req_write_data),
      .req_pin_levels    (req_pin_levels),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_drive_levels  (rsp_drive_levels),
      .rsp_drive_enables (rsp_drive_enables),
      .rsp_event_pending (rsp_event_pending),
      .rsp_bad_address   (rsp_bad_address)
   );

   always #5 clock = ~clock;

   // 32-bit bus word moved into the low or high lane of a pin vector, unused pins dropped
   function automatic logic [63:0] lane_bits(logic [WORD_W-1:0] d, logic hi);
      return (hi ? {d, 32'h0} : {32'h0, d}) & PIN_MASK;
   endfunction

   function automatic logic [ADDR_W-1:0] det_word(int bank, int hi);
      return ADDR_W'(ADDR_DET_BASE + ADDR_DET_STEP * bank + hi);
   endfunction

   function automatic grb_pins_type rand_pins();
      logic [63:0] x;
      x = {$urandom, $urandom};
      return x[NUM_PINS-1:0];
   endfunction

   // One access against the shadow registers. Read data is taken before the
   // write and before this item's events; the other fields show the state after.
   function automatic grb_result_type apply_access(logic [1:0] kind, logic [ADDR_W-1:0] w,
                                                   logic [WORD_W-1:0] d, grb_pins_type pins);
      logic [63:0]       cur, ev, en;
      logic [WORD_W-1:0] rd;
      logic              wr, hit, hi;
      int                pin, sh, base;
      grb_result_type    r;
      cur = 64'(pins) & PIN_MASK;
      wr  = (kind == REQ_WRITE);
      hit = 1'b0;
      hi  = 1'b0;
      rd  = '0;
      en  = '0;
      if (w <= ADDR_FSEL_LAST) begin
         hit = 1'b1;
         for (int k = 0; k < FSEL_PER_WORD; k++) begin
            pin = int'(w) * FSEL_PER_WORD + k;
            sh  = FSEL_BITS * k;
            // pins without a select read 0 and ignore writes
            if (pin < FSEL_PINS) begin
               rd[sh +: FSEL_BITS] = fsel_q[pin];
               if (wr) fsel_q[pin] = d[sh +: FSEL_BITS];
            end
         end
      end else if (w == ADDR_SET || w == ADDR_SET + 6'd1) begin
         hit = 1'b1;
         hi  = (w != ADDR_SET);
         if (wr) latch_q |= lane_bits(d, hi);
      end else if (w == ADDR_CLR || w == ADDR_CLR + 6'd1) begin
         hit = 1'b1;
         hi  = (w != ADDR_CLR);
         if (wr) latch_q &= ~lane_bits(d, hi);
      end else if (w == ADDR_LEV || w == ADDR_LEV + 6'd1) begin
         hit = 1'b1;
         hi  = (w != ADDR_LEV);
         rd  = hi ? cur[63:32] : cur[31:0];
      end else if (w == ADDR_STS || w == ADDR_STS + 6'd1) begin
         hit = 1'b1;
         hi  = (w != ADDR_STS);
         rd  = hi ? status_q[63:32] : status_q[31:0];
         if (wr) status_q &= ~lane_bits(d, hi);
      end else begin
         for (int k = 0; k < NUM_DETECT; k++) begin
            base = ADDR_DET_BASE + ADDR_DET_STEP * k;
            if (int'(w) == base || int'(w) == base + 1) begin
               hit = 1'b1;
               hi  = (int'(w) == base + 1);
               rd  = hi ? det_q[k][63:32] : det_q[k][31:0];
               if (wr) begin
                  det_q[k] = (hi ? {d, det_q[k][31:0]} : {det_q[k][63:32], d}) & PIN_MASK;
               end
            end
         end
      end

      // async banks detect exactly like the sync edge banks
      ev = (det_q[DET_RISE]  &  cur & ~prev_q)
         | (det_q[DET_FALL]  & ~cur &  prev_q)
         | (det_q[DET_HIGH]  &  cur)
         | (det_q[DET_LOW]   & ~cur)
         | (det_q[DET_ARISE] &  cur & ~prev_q)
         | (det_q[DET_AFALL] & ~cur &  prev_q);
      status_q = (status_q | ev) & PIN_MASK;
      prev_q   = cur;

      for (int k = 0; k < FSEL_PINS; k++) en[k] = (fsel_q[k] == FSEL_OUTPUT);

      r.read_data     = (kind == REQ_READ && hit) ? rd : '0;
      r.drive_levels  = latch_q[NUM_PINS-1:0];
      r.drive_enables = en[NUM_PINS-1:0];
      r.event_pending = (status_q != '0);
      r.bad_address   = (kind == REQ_READ || wr) && !hit;
      return r;
   endfunction

   // Sends one item: random idle cycles first, then valid held with a stable
   // payload until the block takes it. Returns just after the accepting edge.
   task automatic send_item(logic [1:0] kind, logic [ADDR_W-1:0] w, logic [WORD_W-1:0] d,
                            grb_pins_type pins);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_word_addr  <= w;
      req_write_data <= d;
      req_pin_levels <= pins;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Result side backpressure, random at the same rate as the sender's gaps.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Prediction: every item taken by the block is run through the shadow model.
   // Sampled at the edge, so both sides see the values from before the edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         access_results.push_back(apply_access(req_type, req_word_addr, req_write_data,
                                               req_pin_levels));
      end
   end

   // Checking of each result against the oldest prediction, plus the watchdog.
   always @(posedge clock) begin : check_results
      grb_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (access_results.size() == 0) begin
            $error("result with no item outstanding");
            error_count++;
         end else begin
            want = access_results.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h", want.read_data, rsp_read_data);
               error_count++;
            end
            if (rsp_drive_levels !== want.drive_levels) begin
               $error("drive_levels: expected %h, actual %h",
                      want.drive_levels, rsp_drive_levels);
               error_count++;
            end
            if (rsp_drive_enables !== want.drive_enables) begin
               $error("drive_enables: expected %h, actual %h",
                      want.drive_enables, rsp_drive_enables);
               error_count++;
            end
            if (rsp_event_pending !== want.event_pending) begin
               $error("event_pending: expected %b, actual %b",
                      want.event_pending, rsp_event_pending);
               error_count++;
            end
            if (rsp_bad_address !== want.bad_address) begin
               $error("bad_address: expected %b, actual %b",
                      want.bad_address, rsp_bad_address);
               error_count++;
            end
         end
      end

      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
         $display("** gpio_register_block: FAILED **");
         $finish;
      end
   end

   // First item after reset: previous sample is all low, so high pins are rising
   // edges. Then a status clear while the pins stay high must not re-raise them.
   task automatic test_first_sample();
      send_item(REQ_WRITE, det_word(DET_RISE, 0), '1, ALL_HIGH);
      send_item(REQ_READ,  ADDR_STS, '0, ALL_HIGH);
      send_item(REQ_READ,  ADDR_STS + 6'd1, '0, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_STS, '1, ALL_HIGH);
   endtask

   // Set and clear are write-one, read back as zero; bits above the last pin drop.
   task automatic test_output_latch();
      send_item(REQ_WRITE, ADDR_SET, '1, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_SET + 6'd1, '1, ALL_HIGH);
      send_item(REQ_READ,  ADDR_SET + 6'd1, '0, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_CLR, 32'h0000_ffff, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_CLR + 6'd1, 32'h0020_0001, ALL_HIGH);
      send_item(REQ_READ,  ADDR_CLR, '0, ALL_HIGH);
   endtask

   // Word 0 all outputs, last word only partly backed by pins, word 1 mixed codes.
   task automatic test_function_select();
      send_item(REQ_WRITE, '0, 32'h0924_9249, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_FSEL_LAST, '1, ALL_HIGH);
      send_item(REQ_READ,  ADDR_FSEL_LAST, '0, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_FSEL_LAST - 6'd4, 32'h1249_2C51, ALL_LOW);
      send_item(REQ_READ,  '0, '0, ALL_LOW);
   endtask

   // Level words follow this item's pins and ignore writes; holes read 0 and flag.
   task automatic test_word_map();
      send_item(REQ_READ,  ADDR_LEV, '0, rand_pins());
      send_item(REQ_READ,  ADDR_LEV + 6'd1, '0, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_LEV, '1, ALL_HIGH);
      send_item(REQ_READ,  ADDR_HOLE_FIRST, '0, ALL_HIGH);
      send_item(REQ_WRITE, ADDR_HOLE_TOP, '1, ALL_HIGH);
      send_item(REQ_READ,  ADDR_DET_END, '0, ALL_HIGH);
      send_item(REQ_TICK,  ADDR_HOLE_FIRST, '1, ALL_HIGH);
      send_item(REQ_SPARE, ADDR_SET, '1, ALL_HIGH);
   endtask

   // Each detect bank but the rising-edge one, and a status clear that loses to a same-item event.
   task automatic test_event_detect();
      send_item(REQ_WRITE, det_word(DET_FALL, 0), '1, ALL_HIGH);
      send_item(REQ_TICK,  '0, '0, ALL_LOW);
      send_item(REQ_WRITE, det_word(DET_HIGH, 1), 32'h003f_ffff, ALL_LOW);
      send_item(REQ_WRITE, det_word(DET_LOW, 0), 32'h0000_ffff, ALL_HIGH);
      send_item(REQ_WRITE, det_word(DET_ARISE, 1), '1, ALL_LOW);
      send_item(REQ_WRITE, det_word(DET_AFALL, 1), '1, ALL_HIGH);
      send_item(REQ_TICK,  '0, '0, ALL_LOW);
      send_item(REQ_WRITE, ADDR_STS + 6'd1, '1, ALL_HIGH);
      send_item(REQ_READ,  ADDR_STS + 6'd1, '0, ALL_HIGH);
      send_item(REQ_READ,  det_word(DET_ARISE, 1), '0, ALL_HIGH);
   endtask

   // Mostly mapped accesses over slowly changing pins so that edges stay rare
   // enough to matter; some fully random words, types and pin vectors as noise.
   task automatic test_random_traffic(int count);
      grb_pins_type      pins;
      logic [1:0]        kind;
      logic [ADDR_W-1:0] w;
      logic [WORD_W-1:0] d;
      int                pick;
      pins = rand_pins();
      for (int n = 0; n < count; n++) begin
         // a long stretch in the middle with no gaps and no stalls
         if (n == count * 2 / 5) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         if (n == count * 3 / 5) begin
            req_idle_pct  = IDLE_PCT;
            rsp_stall_pct = IDLE_PCT;
         end

         pick = $urandom_range(99);
         if (pick < 60) begin
            pins[$urandom_range(NUM_PINS - 1)] ^= 1'b1;
         end else if (pick < 80) begin
            pins ^= rand_pins() & rand_pins();
         end else if (pick < 90) begin
            pins = rand_pins();
         end

         pick = $urandom_range(99);
         if (pick < 8) begin
            kind = REQ_TICK;
         end else if (pick < 11) begin
            kind = REQ_SPARE;
         end else if (pick < 50) begin
            kind = REQ_READ;
         end else begin
            kind = REQ_WRITE;
         end

         w = ($urandom_range(99) < 85) ? ADDR_W'($urandom_range(35))
                                       : ADDR_W'($urandom_range(63));
         d = $urandom;
         // sparse detect enables keep the status word from saturating
         if (kind == REQ_WRITE && int'(w) >= ADDR_DET_BASE && $urandom_range(1) == 1) begin
            d = $urandom & $urandom & $urandom;
         end
         send_item(kind, w, d, pins);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_first_sample();
      test_output_latch();
      test_function_select();
      test_word_map();
      test_event_detect();
      test_random_traffic(RANDOM_ITEMS);

      req_valid <= 1'b0;
      while (access_results.size() != 0) @(posedge clock);
      // a few more cycles to catch any stray result
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("** gpio_register_block: PASSED **");
      end else begin
         $display("** gpio_register_block: FAILED **");
      end
      $finish;
   end

endmodule
